// ===== sv/cfq_pkg.sv =====
package cfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;

    localparam int ADDR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths on the stream ports
    localparam int IO_TAG_BITS   = 16;
    localparam int CLASS_BITS    = 2;
    localparam int STATUS_BITS   = 2;
    localparam int S_DATA_BITS   = 24;
    localparam int M_DATA_BITS   = 24;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [CLASS_BITS-1:0] CLS_ANY = 2'd0;
    localparam logic [CLASS_BITS-1:0] CLS_ONE = 2'd1;
    localparam logic [CLASS_BITS-1:0] CLS_TWO = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic [CLASS_BITS-1:0] cls;
        logic [TAG_BITS-1:0]   tag;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    // Cut or zero-extend a port tag to the stored width
    function automatic logic [TAG_BITS-1:0] tag_to_entry(input logic [IO_TAG_BITS-1:0] t);
        logic [63:0] w;
        w = 64'(t);
        return w[TAG_BITS-1:0];
    endfunction

    function automatic logic [IO_TAG_BITS-1:0] tag_to_port(input logic [TAG_BITS-1:0] t);
        logic [63:0] w;
        w = 64'(t);
        return w[IO_TAG_BITS-1:0];
    endfunction

endpackage

// ===== sv/cfq_ram.sv =====
module cfq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 18
) (
    input  logic                               aclk,
    input  logic                               wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                   wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                   rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/class_selective_fifo_queue.sv =====
// Channel | Dir | tdata fields (lsb first)                      | Notes
// s_      | in  | opcode[0], entry_class[2:1], entry_tag[18:3]  | one command per transfer
// m_      | out | status[1:0], out_class[3:2], out_tag[19:4]     | one result per command
//
// Enqueue and a dequeue that needs no walk (empty queue, class 3) go from IDLE to FINISH,
// which raises m_tvalid once the output register is free. A walked dequeue passes SEEK_RD
// and SEEK_CHK per visited slot and SHIFT_RD and SHIFT_WR per shifted slot, since each
// costs a RAM read and a check or write step on the single read port shared by the search and the gap-closing shift.
// s_tready is high only in idle; a result waits in the output register, so a new command
// is taken under a stalled sink. aresetn (synchronous) clears count and handshake state.
module class_selective_fifo_queue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cfq_pkg::S_DATA_BITS-1:0] s_tdata,  // opcode, entry_class, entry_tag, pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cfq_pkg::M_DATA_BITS-1:0] m_tdata   // status, out_class, out_tag, pad
);

    typedef enum logic [2:0] {
        IDLE,
        SEEK_RD,
        SEEK_CHK,
        SHIFT_RD,
        SHIFT_WR,
        FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [cfq_pkg::CNT_BITS-1:0]    count_reg, count_next;
    logic [cfq_pkg::ADDR_BITS-1:0]   idx_reg, idx_next;
    logic [cfq_pkg::CLASS_BITS-1:0]  cls_reg, cls_next;

    logic [cfq_pkg::STATUS_BITS-1:0] res_status_reg, res_status_next;
    logic [cfq_pkg::CLASS_BITS-1:0]  res_class_reg, res_class_next;
    logic [cfq_pkg::IO_TAG_BITS-1:0] res_tag_reg, res_tag_next;

    logic                            m_valid_reg, m_valid_next;
    logic [cfq_pkg::STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic [cfq_pkg::CLASS_BITS-1:0]  m_class_reg, m_class_next;
    logic [cfq_pkg::IO_TAG_BITS-1:0] m_tag_reg, m_tag_next;

    logic                            in_op;
    logic [cfq_pkg::CLASS_BITS-1:0]  in_cls;
    logic [cfq_pkg::IO_TAG_BITS-1:0] in_tag;

    logic                            wr_en;
    logic [cfq_pkg::ADDR_BITS-1:0]   wr_addr;
    cfq_pkg::entry_t                 wr_entry;
    logic [cfq_pkg::ADDR_BITS-1:0]   rd_addr;
    cfq_pkg::entry_t                 rd_entry;

    logic                            accept;
    logic                            is_full;
    logic                            more_after;
    logic                            more_shift;
    logic                            hit;

    assign in_op  = s_tdata[0];
    assign in_cls = s_tdata[2:1];
    assign in_tag = s_tdata[18:3];

    assign s_tready = (state_reg == IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == cfq_pkg::CNT_BITS'(cfq_pkg::QUEUE_DEPTH));

    // Slot after idx still holds a live entry
    assign more_after = ((cfq_pkg::CNT_BITS'(idx_reg) + 1'b1) < count_reg);
    assign more_shift = ((cfq_pkg::CNT_BITS'(idx_reg) + 2'd2) < count_reg);
    assign hit        = (cls_reg == cfq_pkg::CLS_ANY) || (rd_entry.cls == cls_reg);

    cfq_ram #(
        .DEPTH(cfq_pkg::QUEUE_DEPTH),
        .WIDTH(cfq_pkg::ENTRY_BITS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        cls_next        = cls_reg;
        res_status_next = res_status_reg;
        res_class_next  = res_class_reg;
        res_tag_next    = res_tag_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_class_next    = m_class_reg;
        m_tag_next      = m_tag_reg;

        wr_en        = 1'b0;
        wr_addr      = count_reg[cfq_pkg::ADDR_BITS-1:0];
        wr_entry.cls = in_cls;
        wr_entry.tag = cfq_pkg::tag_to_entry(in_tag);
        rd_addr      = idx_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            IDLE: begin
                if (accept) begin
                    cls_next        = in_cls;
                    idx_next        = '0;
                    res_class_next  = cfq_pkg::CLS_ANY;
                    res_tag_next    = '0;
                    if (in_op == cfq_pkg::OP_ENQ) begin
                        state_next = FINISH;
                        if (is_full) begin
                            res_status_next = cfq_pkg::ST_FULL;
                        end else begin
                            res_status_next = cfq_pkg::ST_DONE;
                            wr_en           = 1'b1;
                            count_next      = count_reg + 1'b1;
                        end
                    end else if (count_reg == '0 ||
                                 (in_cls != cfq_pkg::CLS_ANY &&
                                  in_cls != cfq_pkg::CLS_ONE &&
                                  in_cls != cfq_pkg::CLS_TWO)) begin
                        res_status_next = cfq_pkg::ST_NONE;
                        state_next      = FINISH;
                    end else begin
                        state_next = SEEK_RD;
                    end
                end
            end
            SEEK_RD: begin
                state_next = SEEK_CHK;
            end
            SEEK_CHK: begin
                if (hit) begin
                    res_status_next = cfq_pkg::ST_DONE;
                    res_class_next  = rd_entry.cls;
                    res_tag_next    = cfq_pkg::tag_to_port(rd_entry.tag);
                    if (more_after) begin
                        state_next = SHIFT_RD;
                    end else begin
                        count_next = count_reg - 1'b1;
                        state_next = FINISH;
                    end
                end else if (more_after) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = SEEK_RD;
                end else begin
                    res_status_next = cfq_pkg::ST_NONE;
                    state_next      = FINISH;
                end
            end
            SHIFT_RD: begin
                rd_addr    = idx_reg + 1'b1;
                state_next = SHIFT_WR;
            end
            SHIFT_WR: begin
                // Move the younger neighbor down one slot
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_entry = rd_entry;
                idx_next = idx_reg + 1'b1;
                if (more_shift) begin
                    state_next = SHIFT_RD;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = FINISH;
                end
            end
            FINISH: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_class_next  = res_class_reg;
                    m_tag_next    = res_tag_reg;
                    state_next    = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg        <= idx_next;
        cls_reg        <= cls_next;
        res_status_reg <= res_status_next;
        res_class_reg  <= res_class_next;
        res_tag_reg    <= res_tag_next;
        m_status_reg   <= m_status_next;
        m_class_reg    <= m_class_next;
        m_tag_reg      <= m_tag_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_tag_reg, m_class_reg, m_status_reg};

endmodule

// ===== sv/cfq_checker.sv =====
module cfq_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [cfq_pkg::S_DATA_BITS-1:0] s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [cfq_pkg::M_DATA_BITS-1:0] m_tdata
);

    // A stalled result holds its transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One command in flight: no accept on the cycle after an accept
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == cfq_pkg::ST_DONE ||
                      m_tdata[1:0] == cfq_pkg::ST_FULL ||
                      m_tdata[1:0] == cfq_pkg::ST_NONE))
        else $error("bad status code");

    // Nothing removed means zero class and tag
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != cfq_pkg::ST_DONE |-> m_tdata[23:2] == '0)
        else $error("payload on a failed command");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:20] == '0)
        else $error("pad bits set");

endmodule

bind class_selective_fifo_queue cfq_checker u_cfq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/class_selective_fifo_queue_test.sv =====
module class_selective_fifo_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 2 * cfq_pkg::QUEUE_DEPTH + 32;
    localparam int          PHASE_ITEMS  = 225;
    localparam int          MAX_REPORTS  = 10;

    // class code that is never searched for, and the class reported when nothing is removed
    localparam logic [cfq_pkg::CLASS_BITS-1:0] CLS_BAD  = 2'd3;
    localparam logic [cfq_pkg::CLASS_BITS-1:0] CLS_NONE = 2'd0;

    typedef struct packed {
        logic [cfq_pkg::STATUS_BITS-1:0] status;
        logic [cfq_pkg::CLASS_BITS-1:0]  cls;
        logic [cfq_pkg::IO_TAG_BITS-1:0] tag;
    } queue_result_t;

    typedef struct {
        logic                            op;
        logic [cfq_pkg::CLASS_BITS-1:0]  cls;
        logic [cfq_pkg::IO_TAG_BITS-1:0] tag;
        int                              reps;
        bit                              typed;
        queue_result_t                   want;
    } stim_row_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [cfq_pkg::S_DATA_BITS-1:0] s_tdata  = '0;  // opcode, entry_class, entry_tag, pad
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [cfq_pkg::M_DATA_BITS-1:0] m_tdata;        // status, out_class, out_tag, pad

    cfq_pkg::entry_t held_entries[$];
    queue_result_t   pending_results[$];
    stim_row_t       stim_rows[$];

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    class_selective_fifo_queue uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("class_selective_fifo_queue_test: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Apply one command to the queue image and return the result it must produce.
    function automatic queue_result_t apply_command(
            input logic op,
            input logic [cfq_pkg::CLASS_BITS-1:0] cls,
            input logic [cfq_pkg::IO_TAG_BITS-1:0] tag);
        queue_result_t   res;
        cfq_pkg::entry_t fresh;
        int              hit;
        res.status = cfq_pkg::ST_DONE;
        res.cls    = CLS_NONE;
        res.tag    = '0;
        hit        = -1;
        if (op == cfq_pkg::OP_ENQ) begin
            if (held_entries.size() >= cfq_pkg::QUEUE_DEPTH) begin
                res.status = cfq_pkg::ST_FULL;
            end else begin
                fresh.cls = cls;
                fresh.tag = tag[cfq_pkg::TAG_BITS-1:0];
                held_entries.push_back(fresh);
            end
        end else begin
            if (cls == cfq_pkg::CLS_ANY) begin
                if (held_entries.size() > 0) hit = 0;
            end else if (cls == cfq_pkg::CLS_ONE || cls == cfq_pkg::CLS_TWO) begin
                foreach (held_entries[i]) begin
                    if (hit < 0 && held_entries[i].cls == cls) hit = i;
                end
            end
            if (hit >= 0) begin
                res.cls = held_entries[hit].cls;
                res.tag = held_entries[hit].tag;
                held_entries.delete(hit);
            end else begin
                res.status = cfq_pkg::ST_NONE;
            end
        end
        return res;
    endfunction

    task automatic issue_command(input logic op, input logic [cfq_pkg::CLASS_BITS-1:0] cls,
                                 input logic [cfq_pkg::IO_TAG_BITS-1:0] tag, input bit typed,
                                 input queue_result_t want);
        queue_result_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(cfq_pkg::S_DATA_BITS - cfq_pkg::IO_TAG_BITS
                       - cfq_pkg::CLASS_BITS - 1){1'b0}}, tag, cls, op};
        do @(posedge aclk); while (!s_tready);
        // the queue image advances on every transfer, typed rows included
        predicted = apply_command(op, cls, tag);
        pending_results.push_back(typed ? want : predicted);
    endtask

    function automatic void add_row(input logic op, input logic [cfq_pkg::CLASS_BITS-1:0] cls,
                                    input logic [cfq_pkg::IO_TAG_BITS-1:0] tag,
                                    input int reps, input bit typed,
                                    input logic [cfq_pkg::STATUS_BITS-1:0] status,
                                    input logic [cfq_pkg::CLASS_BITS-1:0] ocls,
                                    input logic [cfq_pkg::IO_TAG_BITS-1:0] otag);
        stim_row_t row;
        row.op          = op;
        row.cls         = cls;
        row.tag         = tag;
        row.reps        = reps;
        row.typed       = typed;
        row.want.status = status;
        row.want.cls    = ocls;
        row.want.tag    = otag;
        stim_rows.push_back(row);
    endfunction

    always @(posedge aclk) begin : result_check
        queue_result_t got;
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.cls    = m_tdata[3:2];
            got.tag    = m_tdata[19:4];
            if (pending_results.size() == 0) begin
                flag_error($sformatf("unexpected transfer: status %0d class %0d tag %h",
                                     got.status, got.cls, got.tag));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.cls !== want.cls
                        || got.tag !== want.tag) begin
                    flag_error($sformatf({"mismatch: expected status %0d class %0d tag %h,",
                                          " got status %0d class %0d tag %h"},
                                         want.status, want.cls, want.tag,
                                         got.status, got.cls, got.tag));
                end
            end
        end
    end

    initial begin : stimulus
        int                              k;
        int                              n;
        int                              enq_pct;
        logic                            op;
        logic [cfq_pkg::CLASS_BITS-1:0]  cls;
        logic [cfq_pkg::IO_TAG_BITS-1:0] tag;
        int unsigned                     pick;
        queue_result_t                   unused;

        unused = '0;

        // empty queue after reset
        add_row(cfq_pkg::OP_DEQ, cfq_pkg::CLS_ANY, 16'h0000, 1, 1,
                cfq_pkg::ST_NONE, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_DEQ, cfq_pkg::CLS_ONE, 16'hFFFF, 1, 1,
                cfq_pkg::ST_NONE, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_DEQ, CLS_BAD, 16'h5A5A, 1, 1,
                cfq_pkg::ST_NONE, CLS_NONE, 16'h0000);
        // every class stored as given, tag extremes
        add_row(cfq_pkg::OP_ENQ, cfq_pkg::CLS_ONE, 16'h0000, 1, 1,
                cfq_pkg::ST_DONE, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_ENQ, cfq_pkg::CLS_TWO, 16'hFFFF, 1, 1,
                cfq_pkg::ST_DONE, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_ENQ, cfq_pkg::CLS_ANY, 16'h1234, 1, 1,
                cfq_pkg::ST_DONE, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_ENQ, CLS_BAD, 16'h8001, 1, 1,
                cfq_pkg::ST_DONE, CLS_NONE, 16'h0000);
        // class 3 is never searched for, even with a class 3 entry held
        add_row(cfq_pkg::OP_DEQ, CLS_BAD, 16'h0000, 1, 1,
                cfq_pkg::ST_NONE, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_DEQ, cfq_pkg::CLS_TWO, 16'h0000, 1, 1,
                cfq_pkg::ST_DONE, cfq_pkg::CLS_TWO, 16'hFFFF);
        add_row(cfq_pkg::OP_DEQ, cfq_pkg::CLS_TWO, 16'hFFFF, 1, 1,
                cfq_pkg::ST_NONE, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_DEQ, cfq_pkg::CLS_ONE, 16'hFFFF, 1, 1,
                cfq_pkg::ST_DONE, cfq_pkg::CLS_ONE, 16'h0000);
        add_row(cfq_pkg::OP_DEQ, cfq_pkg::CLS_ONE, 16'h0000, 1, 1,
                cfq_pkg::ST_NONE, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_DEQ, cfq_pkg::CLS_ANY, 16'h0000, 1, 1,
                cfq_pkg::ST_DONE, cfq_pkg::CLS_ANY, 16'h1234);
        add_row(cfq_pkg::OP_DEQ, cfq_pkg::CLS_ANY, 16'h0000, 1, 1,
                cfq_pkg::ST_DONE, CLS_BAD, 16'h8001);
        add_row(cfq_pkg::OP_DEQ, cfq_pkg::CLS_ANY, 16'h0000, 1, 1,
                cfq_pkg::ST_NONE, CLS_NONE, 16'h0000);
        // fill to the brim, then overflow
        add_row(cfq_pkg::OP_ENQ, cfq_pkg::CLS_ONE, 16'hA000, 8, 1,
                cfq_pkg::ST_DONE, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_ENQ, cfq_pkg::CLS_TWO, 16'hB000, 8, 1,
                cfq_pkg::ST_DONE, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_ENQ, cfq_pkg::CLS_ONE, 16'hC000, 1, 1,
                cfq_pkg::ST_FULL, CLS_NONE, 16'h0000);
        // remove from the middle and close the gap
        add_row(cfq_pkg::OP_DEQ, cfq_pkg::CLS_TWO, 16'h0000, 1, 1,
                cfq_pkg::ST_DONE, cfq_pkg::CLS_TWO, 16'hB000);
        add_row(cfq_pkg::OP_ENQ, cfq_pkg::CLS_TWO, 16'hD000, 1, 0,
                cfq_pkg::ST_DONE, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_ENQ, cfq_pkg::CLS_ONE, 16'hC001, 1, 1,
                cfq_pkg::ST_FULL, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_DEQ, cfq_pkg::CLS_TWO, 16'h0000, 8, 0,
                cfq_pkg::ST_DONE, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_DEQ, cfq_pkg::CLS_ANY, 16'h0000, 8, 0,
                cfq_pkg::ST_DONE, CLS_NONE, 16'h0000);
        add_row(cfq_pkg::OP_DEQ, cfq_pkg::CLS_ANY, 16'h0000, 1, 1,
                cfq_pkg::ST_NONE, CLS_NONE, 16'h0000);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[r]) begin
            for (k = 0; k < stim_rows[r].reps; k++) begin
                issue_command(stim_rows[r].op, stim_rows[r].cls,
                              stim_rows[r].tag + cfq_pkg::IO_TAG_BITS'(k),
                              stim_rows[r].typed, stim_rows[r].want);
            end
        end

        enq_pct = 50;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
                default: begin src_idle_pct = 22; sink_stall_pct = 22; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // swing between filling, balanced and draining stretches
                if (n % 40 == 0) begin
                    pick    = $urandom_range(0, 2);
                    enq_pct = (pick == 0) ? 85 : (pick == 1) ? 50 : 20;
                end
                op   = ($urandom_range(0, 99) < enq_pct) ? cfq_pkg::OP_ENQ : cfq_pkg::OP_DEQ;
                pick = $urandom_range(0, 9);
                if (op == cfq_pkg::OP_ENQ) begin
                    cls = (pick < 4) ? cfq_pkg::CLS_ONE : (pick < 8) ? cfq_pkg::CLS_TWO :
                          (pick == 8) ? cfq_pkg::CLS_ANY : CLS_BAD;
                end else begin
                    cls = (pick < 3) ? cfq_pkg::CLS_ANY : (pick < 6) ? cfq_pkg::CLS_ONE :
                          (pick < 9) ? cfq_pkg::CLS_TWO : CLS_BAD;
                end
                if ($urandom_range(0, 15) == 0) begin
                    tag = {cfq_pkg::IO_TAG_BITS{$urandom_range(0, 1) == 1}};
                end else begin
                    tag = cfq_pkg::IO_TAG_BITS'($urandom);
                end
                issue_command(op, cls, tag, 1'b0, unused);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("class_selective_fifo_queue_test: clean");
        end else begin
            $display("class_selective_fifo_queue_test: errors");
        end
        $finish;
    end

endmodule
